// ===== sv/msched_pkg.sv =====
// Shared types, codes and constants of the multi-policy CPU scheduler.
package msched_pkg;

  localparam int READY_DEPTH_DEF = 32;
  localparam int NUM_CPUS_DEF    = 8;
  localparam int NW              = 5;   // holds a CPU count up to 16
  localparam int ENTRY_W         = 24;  // {task, time}

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_SLICE  = 2'd1;
  localparam logic [1:0] CFG_CPUS   = 2'd2;

  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_SRTF = 2'd2;

  localparam logic [2:0] FN_WAKE    = 3'd0;
  localparam logic [2:0] FN_PREEMPT = 3'd1;
  localparam logic [2:0] FN_YIELD   = 3'd2;
  localparam logic [2:0] FN_TERM    = 3'd3;
  localparam logic [2:0] FN_IDLE    = 3'd4;

  typedef enum logic [2:0] {
    ACT_DISPATCH = 3'd0,
    ACT_IDLE     = 3'd1,
    ACT_PREEMPT  = 3'd2,
    ACT_WAKE_CPU = 3'd3,
    ACT_NONE     = 3'd4,
    ACT_FULL     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    TGT_ZERO = 2'd0,
    TGT_CPU  = 2'd1,
    TGT_SCAN = 2'd2,
    TGT_MAX  = 2'd3
  } tgt_e;

  typedef struct packed {
    logic    latch_in;
    logic    enq_wake;
    logic    enq_pre;
    logic    clr_valid;
    logic    wscan_init;
    logic    wscan_step;
    logic    dscan_init;
    logic    dscan_step;
    logic    shift_init;
    logic    shift_step;
    logic    res_we;
    action_e res_act;
    tgt_e    res_tgt;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic is_wake;
    logic is_bad;
    logic is_pre;
    logic is_idle_req;
    logic full;
    logic cur_valid;
    logic cnt_zero;
    logic wscan_end;
    logic wscan_hit;
    logic wscan_pre;
    logic dscan_done;
    logic shift_done;
    logic out_blocked;
  } sts_t;

endpackage

// ===== sv/msched_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/msched_ctrl.sv =====
// Sequencing state machine of the scheduler.
module msched_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msched_pkg::sts_t   sts_i,
  output msched_pkg::cmd_t   cmd_o
);
  import msched_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_WSCAN = 7'b0000100,
    S_DISP  = 7'b0001000,
    S_DSCAN = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e st_q, st_d;

  assign in_stall_o = (st_q != S_IDLE);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    cmd_o.res_act = ACT_NONE;
    cmd_o.res_tgt = TGT_ZERO;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_wake) begin
          if (sts_i.full) begin
            cmd_o.res_we  = 1'b1;
            cmd_o.res_act = ACT_FULL;
            st_d = S_DONE;
          end else begin
            cmd_o.enq_wake   = 1'b1;
            cmd_o.wscan_init = 1'b1;
            st_d = S_WSCAN;
          end
        end else if (sts_i.is_bad) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_tgt = TGT_CPU;
          st_d = S_DONE;
        end else if (sts_i.is_pre) begin
          if (sts_i.cur_valid) begin
            cmd_o.clr_valid = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_we  = 1'b1;
              cmd_o.res_act = ACT_FULL;
              cmd_o.res_tgt = TGT_CPU;
              st_d = S_DONE;
            end else begin
              cmd_o.enq_pre = 1'b1;
              st_d = S_DISP;
            end
          end else begin
            st_d = S_DISP;
          end
        end else if (sts_i.is_idle_req) begin
          if (sts_i.cur_valid) begin
            cmd_o.res_we  = 1'b1;
            cmd_o.res_tgt = TGT_CPU;
            st_d = S_DONE;
          end else begin
            st_d = S_DISP;
          end
        end else begin
          cmd_o.clr_valid = 1'b1;
          st_d = S_DISP;
        end
      end
      S_WSCAN: begin
        if (sts_i.wscan_end) begin
          cmd_o.res_we = 1'b1;
          if (sts_i.wscan_pre) begin
            cmd_o.res_act = ACT_PREEMPT;
            cmd_o.res_tgt = TGT_MAX;
          end
          st_d = S_DONE;
        end else if (sts_i.wscan_hit) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_act = ACT_WAKE_CPU;
          cmd_o.res_tgt = TGT_SCAN;
          st_d = S_DONE;
        end else begin
          cmd_o.wscan_step = 1'b1;
        end
      end
      S_DISP: begin
        if (sts_i.cnt_zero) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_act = ACT_IDLE;
          cmd_o.res_tgt = TGT_CPU;
          st_d = S_DONE;
        end else begin
          cmd_o.dscan_init = 1'b1;
          st_d = S_DSCAN;
        end
      end
      S_DSCAN: begin
        cmd_o.dscan_step = 1'b1;
        if (sts_i.dscan_done) begin
          cmd_o.shift_init = 1'b1;
          st_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.res_we  = 1'b1;
          cmd_o.res_act = ACT_DISPATCH;
          cmd_o.res_tgt = TGT_CPU;
          st_d = S_DONE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == S_DEC)
    else $error("accepted beat did not reach decode");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("state register not one-hot");
  a_result_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_we |=> st_q == S_DONE)
    else $error("result written without finishing the event");
`endif

endmodule

// ===== sv/msched_dp.sv =====
// Datapath of the scheduler: config, ready table, running table, result registers.
module msched_dp #(
  parameter int READY_DEPTH = msched_pkg::READY_DEPTH_DEF,
  parameter int NUM_CPUS    = msched_pkg::NUM_CPUS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  input  logic [2:0]       func_i,
  input  logic [2:0]       cpu_i,
  input  logic [7:0]       task_id_i,
  input  logic [15:0]      time_left_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [2:0]       action_o,
  output logic [2:0]       target_cpu_o,
  output logic [7:0]       dispatched_task_o,
  output logic [7:0]       slice_out_o,
  input  msched_pkg::cmd_t cmd_i,
  output msched_pkg::sts_t sts_o
);
  import msched_pkg::*;

  localparam int AW  = $clog2(READY_DEPTH);
  localparam int CW  = $clog2(READY_DEPTH + 1);
  localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // configuration
  logic [1:0] policy_q;
  logic [7:0] slice_q;
  logic [3:0] cin_q;

  // latched event
  logic [2:0]  func_q, cpu_q;
  logic [7:0]  task_q;
  logic [15:0] time_q;

  // tables
  logic [CW-1:0]       rcnt_q;
  logic [NUM_CPUS-1:0] valid_q;
  logic [7:0]          rtask_q [NUM_CPUS];
  logic [15:0]         rtime_q [NUM_CPUS];

  // scans
  logic [NW-1:0] wi_q, maxcpu_q;
  logic [15:0]   max_time_q;
  logic [CW-1:0] rd_k_q;
  logic [AW-1:0] k_q, pos_q, pos_n;
  logic          pv_q;
  logic [7:0]    best_task_q;
  logic [15:0]   best_time_q;

  // result
  action_e    res_act_q, out_act_q;
  logic [2:0] res_tgt_q, out_tgt_q;
  logic [7:0] res_task_q, out_task_q, res_slice_q, out_slice_q;
  logic       out_valid_q;

  logic [NW-1:0]      n_w;
  logic [CIW-1:0]     cpu_idx, wi_idx;
  logic [CW-1:0]      limit;
  logic               mem_we, upd, commit;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic [2:0]         tgt_w;

  assign n_w = (cin_q == 4'd0) ? NW'(1) :
               ({1'b0, cin_q} > NW'(NUM_CPUS)) ? NW'(NUM_CPUS) : {1'b0, cin_q};
  assign cpu_idx = CIW'(cpu_q);
  assign wi_idx  = CIW'(wi_q);
  assign limit   = (policy_q == POL_SRTF) ? rcnt_q : CW'(1);
  assign commit  = cmd_i.res_we && (cmd_i.res_act == ACT_DISPATCH);

  assign upd   = cmd_i.dscan_step && pv_q &&
                 ((k_q == '0) || (mem_rdata[15:0] < best_time_q));
  assign pos_n = upd ? k_q : pos_q;

  assign mem_we    = cmd_i.enq_wake || cmd_i.enq_pre || (cmd_i.shift_step && pv_q);
  assign mem_waddr = (cmd_i.shift_step) ? (k_q - AW'(1)) : rcnt_q[AW-1:0];
  assign mem_wdata = cmd_i.enq_wake ? {task_q, time_q} :
                     cmd_i.enq_pre  ? {rtask_q[cpu_idx], time_q} : mem_rdata;

  msched_ram #(.WIDTH(ENTRY_W), .DEPTH(READY_DEPTH)) u_ready (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(rd_k_q[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  // status
  always_comb begin
    sts_o             = '0;
    sts_o.is_wake     = (func_q == FN_WAKE);
    sts_o.is_bad      = (func_q > FN_IDLE) || ({2'b00, cpu_q} >= n_w);
    sts_o.is_pre      = (func_q == FN_PREEMPT);
    sts_o.is_idle_req = (func_q == FN_IDLE);
    sts_o.full        = (rcnt_q == CW'(READY_DEPTH));
    sts_o.cur_valid   = valid_q[cpu_idx];
    sts_o.cnt_zero    = (rcnt_q == '0);
    sts_o.wscan_end   = (wi_q >= n_w);
    sts_o.wscan_hit   = !valid_q[wi_idx];
    sts_o.wscan_pre   = (policy_q == POL_SRTF) && (time_q < max_time_q);
    sts_o.dscan_done  = pv_q && (CW'(k_q) == limit - CW'(1));
    sts_o.shift_done  = (rd_k_q >= rcnt_q) && !pv_q;
    sts_o.out_blocked = out_valid_q && out_stall_i;
  end

  always_comb begin
    case (cmd_i.res_tgt)
      TGT_CPU:  tgt_w = cpu_q;
      TGT_SCAN: tgt_w = wi_q[2:0];
      TGT_MAX:  tgt_w = maxcpu_q[2:0];
      default:  tgt_w = 3'd0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= 2'd0;
      slice_q     <= 8'd10;
      cin_q       <= 4'd1;
      rcnt_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY: policy_q <= cfg_data_i[1:0];
          CFG_SLICE:  slice_q  <= cfg_data_i;
          CFG_CPUS:   cin_q    <= cfg_data_i[3:0];
          default:    ;
        endcase
      end
      if (cmd_i.enq_wake || cmd_i.enq_pre) begin
        rcnt_q <= rcnt_q + CW'(1);
      end else if (commit) begin
        rcnt_q <= rcnt_q - CW'(1);
      end
      if (cmd_i.clr_valid) begin
        valid_q[cpu_idx] <= 1'b0;
      end else if (commit) begin
        valid_q[cpu_idx] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_i;
      cpu_q  <= cpu_i;
      task_q <= task_id_i;
      time_q <= time_left_i;
    end
    if (commit) begin
      rtask_q[cpu_idx] <= best_task_q;
      rtime_q[cpu_idx] <= best_time_q;
    end
    if (cmd_i.wscan_init) begin
      wi_q <= '0;
    end else if (cmd_i.wscan_step) begin
      if ((wi_q == '0) || (rtime_q[wi_idx] > max_time_q)) begin
        max_time_q <= rtime_q[wi_idx];
        maxcpu_q   <= wi_q;
      end
      wi_q <= wi_q + NW'(1);
    end
    if (cmd_i.dscan_init) begin
      rd_k_q <= '0;
      pv_q   <= 1'b0;
    end else if (cmd_i.shift_init) begin
      rd_k_q <= CW'(pos_n) + CW'(1);
      pv_q   <= 1'b0;
    end else if (cmd_i.dscan_step || cmd_i.shift_step) begin
      if (rd_k_q < (cmd_i.dscan_step ? limit : rcnt_q)) begin
        rd_k_q <= rd_k_q + CW'(1);
        k_q    <= rd_k_q[AW-1:0];
        pv_q   <= 1'b1;
      end else begin
        pv_q   <= 1'b0;
      end
    end
    if (upd) begin
      pos_q       <= k_q;
      best_task_q <= mem_rdata[23:16];
      best_time_q <= mem_rdata[15:0];
    end
    if (cmd_i.res_we) begin
      res_act_q   <= cmd_i.res_act;
      res_tgt_q   <= tgt_w;
      res_task_q  <= commit ? best_task_q : 8'd0;
      res_slice_q <= (commit && policy_q == POL_RR) ? slice_q : 8'd0;
    end
    if (cmd_i.load_out) begin
      out_act_q   <= res_act_q;
      out_tgt_q   <= res_tgt_q;
      out_task_q  <= res_task_q;
      out_slice_q <= res_slice_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = out_act_q;
  assign target_cpu_o      = out_tgt_q;
  assign dispatched_task_o = out_task_q;
  assign slice_out_o       = out_slice_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= CW'(READY_DEPTH))
    else $error("ready count beyond table depth");
  a_commit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> rcnt_q != '0)
    else $error("dispatch from an empty ready table");
  a_enq_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enq_wake || cmd_i.enq_pre) |-> rcnt_q < CW'(READY_DEPTH))
    else $error("enqueue into a full ready table");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// ===== sv/multi_policy_cpu_scheduler.sv =====
// Top level of the multi-policy CPU scheduler.
//
// Input channel: one beat per scheduling event (func_i, cpu_i, task_id_i,
// time_left_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one beat per event (action_o, target_cpu_o,
// dispatched_task_o, slice_out_o), taken when out_valid_o is high and
// out_stall_i is low. Configuration: cfg_we_i writes cfg_data_i into the
// register cfg_idx_i (0 policy, 1 slice length, 2 CPUs in use); write only
// while no event is in flight.
// One event at a time. A wake scans the CPUs in use for an idle one, and a
// dispatch reads the ready entries (all entries in SRTF mode to find the
// shortest, one in the other modes) and then moves each entry behind the
// chosen one down to close the gap, reading one ready entry per cycle.
// Reset empties the ready table, marks every CPU idle and restores the
// register defaults. While the receiver stalls, the result beat holds, and
// the block may take and finish one more event, then waits to hand it over.
module multi_policy_cpu_scheduler #(
  parameter int READY_DEPTH = msched_pkg::READY_DEPTH_DEF,
  parameter int NUM_CPUS    = msched_pkg::NUM_CPUS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  cpu_i,
  input  logic [7:0]  task_id_i,
  input  logic [15:0] time_left_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [2:0]  target_cpu_o,
  output logic [7:0]  dispatched_task_o,
  output logic [7:0]  slice_out_o
);
  import msched_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the event
  msched_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // hold the tables and the result beat
  msched_dp #(.READY_DEPTH(READY_DEPTH), .NUM_CPUS(NUM_CPUS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .cpu_i            (cpu_i),
    .task_id_i        (task_id_i),
    .time_left_i      (time_left_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .action_o         (action_o),
    .target_cpu_o     (target_cpu_o),
    .dispatched_task_o(dispatched_task_o),
    .slice_out_o      (slice_out_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

// ===== tb/multi_policy_cpu_scheduler_test.sv =====
// Testbench for the multi-policy CPU scheduler: directed table, random events, checked by a predictor.
`timescale 1ns / 100ps

module multi_policy_cpu_scheduler_test;
  import msched_pkg::*;

  localparam int DEPTH = 32;
  localparam int CPUS  = 8;
  localparam int RANDOM_EVENTS = 1400;

  typedef struct {
    logic [2:0]  func;
    logic [2:0]  cpu;
    logic [7:0]  task_id;
    logic [15:0] tleft;
  } event_t;

  typedef struct packed {
    action_e    act;
    logic [2:0] tgt;
    logic [7:0] task_id;
    logic [7:0] slice;
  } decision_t;

  // Directed row: the event, and optionally a typed-in decision.
  typedef struct {
    event_t    ev;
    bit        fixed;
    decision_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [2:0]  cpu_i = '0;
  logic [7:0]  task_id_i = '0;
  logic [15:0] time_left_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  action_o;
  logic [2:0]  target_cpu_o;
  logic [7:0]  dispatched_task_o;
  logic [7:0]  slice_out_o;

  multi_policy_cpu_scheduler uut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: ready table kept as an age-ordered queue of entries.
  logic [1:0]  pol;
  logic [7:0]  slice_len;
  logic [3:0]  cpus_cfg;
  logic [7:0]  rdy_task[$];
  logic [15:0] rdy_time[$];
  bit          run_busy[CPUS];
  logic [7:0]  run_task[CPUS];
  logic [15:0] run_time[CPUS];

  decision_t pending_decisions[$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic int served();
    int n;
    n = cpus_cfg;
    if (n == 0) n = 1;
    if (n > CPUS) n = CPUS;
    return n;
  endfunction

  function automatic decision_t mk(action_e a, int t, int k, int s);
    decision_t d;
    d.act = a; d.tgt = t[2:0]; d.task_id = k[7:0]; d.slice = s[7:0];
    return d;
  endfunction

  function automatic decision_t dispatch_to(int c);
    int pos;
    decision_t d;
    pos = 0;
    if (rdy_task.size() == 0) begin
      run_busy[c] = 0;
      return mk(ACT_IDLE, c, 0, 0);
    end
    if (pol == POL_SRTF)
      for (int k = 1; k < rdy_task.size(); k++)
        if (rdy_time[k] < rdy_time[pos]) pos = k;
    run_busy[c] = 1;
    run_task[c] = rdy_task[pos];
    run_time[c] = rdy_time[pos];
    rdy_task.delete(pos);
    rdy_time.delete(pos);
    d = mk(ACT_DISPATCH, c, run_task[c], pol == POL_RR ? slice_len : 0);
    return d;
  endfunction

  function automatic decision_t schedule(event_t ev);
    int n, max_cpu;
    logic [15:0] max_t;
    bit any;
    n = served();
    if (ev.func == FN_WAKE) begin
      if (rdy_task.size() >= DEPTH) return mk(ACT_FULL, 0, 0, 0);
      rdy_task.push_back(ev.task_id);
      rdy_time.push_back(ev.tleft);
      any = 0; max_cpu = 0; max_t = 0;
      for (int i = 0; i < n; i++) begin
        if (!run_busy[i]) return mk(ACT_WAKE_CPU, i, 0, 0);
        if (!any || run_time[i] > max_t) begin
          max_t = run_time[i]; max_cpu = i; any = 1;
        end
      end
      if (pol == POL_SRTF && any && ev.tleft < max_t) return mk(ACT_PREEMPT, max_cpu, 0, 0);
      return mk(ACT_NONE, 0, 0, 0);
    end
    if (ev.func > FN_IDLE || ev.cpu >= n) return mk(ACT_NONE, ev.cpu, 0, 0);
    if (ev.func == FN_PREEMPT) begin
      if (run_busy[ev.cpu]) begin
        run_busy[ev.cpu] = 0;
        if (rdy_task.size() >= DEPTH) return mk(ACT_FULL, ev.cpu, 0, 0);
        rdy_task.push_back(run_task[ev.cpu]);
        rdy_time.push_back(ev.tleft);
      end
    end else if (ev.func == FN_YIELD || ev.func == FN_TERM) begin
      run_busy[ev.cpu] = 0;
    end else if (run_busy[ev.cpu]) begin
      return mk(ACT_NONE, ev.cpu, 0, 0);
    end
    return dispatch_to(ev.cpu);
  endfunction

  // Result side: random stall per beat, compare against the oldest expectation.
  initial begin
    decision_t w;
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_decisions.size() == 0) begin
          report("unexpected beat action", action_o, -1);
        end else begin
          w = pending_decisions.pop_front();
          if (action_o !== w.act) report("action", action_o, w.act);
          if (target_cpu_o !== w.tgt) report("target_cpu", target_cpu_o, w.tgt);
          if (dispatched_task_o !== w.task_id)
            report("dispatched_task", dispatched_task_o, w.task_id);
          if (slice_out_o !== w.slice) report("slice_out", slice_out_o, w.slice);
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send(event_t ev, bit fixed, decision_t want);
    decision_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i <= ev.func; cpu_i <= ev.cpu; task_id_i <= ev.task_id; time_left_i <= ev.tleft;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    p = schedule(ev);
    if (fixed && p != want) report("directed row action", p.act, want.act);
    pending_decisions.push_back(p);
  endtask

  // Wait for the block to go quiet, then hold off for the slowest event.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] idx, logic [7:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) pol = val[1:0];
    else if (idx == CFG_SLICE) slice_len = val;
    else if (idx == CFG_CPUS) cpus_cfg = val[3:0];
  endtask

  function automatic event_t ev_of(int f, int c, int k, int t);
    event_t e;
    e.func = f[2:0]; e.cpu = c[2:0]; e.task_id = k[7:0]; e.tleft = t[15:0];
    return e;
  endfunction

  function automatic row_t row(event_t e, bit fx, decision_t d);
    row_t r;
    r.ev = e; r.fixed = fx; r.want = d;
    return r;
  endfunction

  function automatic event_t random_event();
    int r;
    event_t e;
    r = $urandom_range(0, 99);
    e.cpu = $urandom_range(0, 7);
    e.task_id = $urandom;
    e.tleft = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                          : 16'($urandom);
    if (r < 40) e.func = FN_WAKE;
    else if (r < 55) e.func = FN_PREEMPT;
    else if (r < 70) e.func = FN_YIELD;
    else if (r < 80) e.func = FN_TERM;
    else if (r < 96) e.func = FN_IDLE;
    else e.func = $urandom_range(5, 7);
    // Keep most events on served CPUs.
    if (e.func != FN_WAKE && $urandom_range(0, 9) != 0) e.cpu = $urandom_range(0, served() - 1);
    return e;
  endfunction

  initial begin
    row_t dir[$];
    decision_t nd;
    logic [7:0] slices[4];
    logic [3:0] cpu_set[5];
    pol = 0; slice_len = 10; cpus_cfg = 1;
    for (int i = 0; i < CPUS; i++) run_busy[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, empty table, bad func, out-of-range CPU, extremes.
    nd = mk(ACT_NONE, 0, 0, 0);
    dir.push_back(row(ev_of(FN_IDLE, 0, 0, 0), 1, mk(ACT_IDLE, 0, 0, 0)));
    dir.push_back(row(ev_of(FN_YIELD, 0, 0, 0), 1, mk(ACT_IDLE, 0, 0, 0)));
    dir.push_back(row(ev_of(FN_PREEMPT, 0, 0, 0), 1, mk(ACT_IDLE, 0, 0, 0)));
    dir.push_back(row(ev_of(5, 3, 0, 0), 1, mk(ACT_NONE, 3, 0, 0)));
    dir.push_back(row(ev_of(7, 7, 255, 65535), 1, mk(ACT_NONE, 7, 0, 0)));
    dir.push_back(row(ev_of(FN_IDLE, 7, 0, 0), 1, mk(ACT_NONE, 7, 0, 0)));
    dir.push_back(row(ev_of(FN_WAKE, 5, 255, 65535), 1, mk(ACT_WAKE_CPU, 0, 0, 0)));
    dir.push_back(row(ev_of(FN_IDLE, 0, 0, 0), 1, mk(ACT_DISPATCH, 0, 255, 0)));
    dir.push_back(row(ev_of(FN_WAKE, 0, 0, 0), 1, nd));
    dir.push_back(row(ev_of(FN_IDLE, 0, 0, 0), 1, mk(ACT_NONE, 0, 0, 0)));
    dir.push_back(row(ev_of(FN_PREEMPT, 0, 0, 1234), 1, mk(ACT_DISPATCH, 0, 0, 0)));
    dir.push_back(row(ev_of(FN_TERM, 0, 0, 0), 0, nd));
    dir.push_back(row(ev_of(FN_TERM, 0, 0, 0), 1, mk(ACT_IDLE, 0, 0, 0)));
    foreach (dir[i]) send(dir[i].ev, dir[i].fixed, dir[i].want);

    // Fill the ready table past full with the one CPU in use idle, then preempt into a full table.
    for (int i = 0; i < DEPTH + 2; i++) send(ev_of(FN_WAKE, 0, i, 1000 - i), 0, nd);
    send(ev_of(FN_IDLE, 0, 0, 0), 0, nd);
    send(ev_of(FN_WAKE, 0, 9, 9), 1, nd);
    send(ev_of(FN_PREEMPT, 0, 0, 5), 1, mk(ACT_FULL, 0, 0, 0));

    // SRTF and round robin, with every CPU busy, plus extremes of slice and CPU count.
    configure(CFG_POLICY, 2);
    configure(CFG_CPUS, 8);
    for (int c = 0; c < CPUS; c++) send(ev_of(FN_IDLE, c, 0, 0), 0, nd);
    send(ev_of(FN_WAKE, 0, 77, 0), 0, nd);
    send(ev_of(FN_WAKE, 0, 78, 65535), 0, nd);
    for (int c = 0; c < CPUS; c++) send(ev_of(FN_TERM, c, 0, 0), 0, nd);

    slices = '{8'd1, 8'd255, 8'd0, 8'd10};
    cpu_set = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4};
    for (int ph = 0; ph < 8; ph++) begin
      configure(CFG_POLICY, 8'(ph % 4));
      configure(CFG_SLICE, slices[ph % 4]);
      configure(CFG_CPUS, cpu_set[ph % 5]);
      for (int i = 0; i < RANDOM_EVENTS / 8; i++) begin
        send(random_event(), 0, nd);
        // Let the pipeline empty once per phase.
        if (i == 40) begin
          in_valid_i <= 1'b0;
          while (pending_decisions.size() != 0) @(posedge clk_i);
        end
      end
    end
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
